FILE: hw/rtl/tpvs_pkg.sv
`default_nettype none
package tpvs_pkg;
    localparam int IN_TDATA_W  = 304;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_TUSER_W = 1;
    localparam int CFG_W       = 23;
    localparam logic [CFG_W-1:0] THR_RESET = 23'd16384;
    localparam int DISP_W      = 32;
    localparam int ERR_W       = 24;
    localparam int COEF_W      = 24;
    localparam int C_W         = 31;
    localparam int VEL_W       = 32;
    localparam int WGT_W       = 32;
    localparam int LANES       = 4;
    localparam int DIV1_DW     = 62;
    localparam int DIV1_QW     = 32;
    localparam int DIV2_DW     = 63;
    localparam int DIV2_QW     = 33;
    localparam logic [VEL_W-1:0] VEL_NONE = 32'h8000_0000;
    localparam logic [WGT_W-1:0] WGT_MAX  = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

FILE: hw/rtl/tpvs_div.sv
`default_nettype none
module tpvs_div #(
    parameter int DW = 62,
    parameter int QW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [QW-1:0] i_low,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);
    logic [DW-1:0] r_rem [QW-1];
    logic [QW-1:0] r_low [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] s_rem;
        logic [DW-1:0] s_den;
        logic [QW-1:0] s_low;
        logic [QW-1:0] s_quo;
        logic [DW:0]   s_try;
        logic [DW:0]   s_diff;
        logic          s_ge;
        logic [DW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign s_rem = i_rem;
            assign s_den = i_den;
            assign s_low = i_low;
            assign s_quo = '0;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_low = r_low[k-1];
            assign s_quo = r_quo[k-1];
        end

        always_comb begin
            s_try  = {s_rem, s_low[QW-1]};
            s_ge   = s_try >= {1'b0, s_den};
            s_diff = s_try - {1'b0, s_den};
            n_rem  = s_ge ? s_diff[DW-1:0] : s_try[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {s_quo[QW-2:0], s_ge};
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_low[k] <= {s_low[QW-2:0], 1'b0};
                    r_den[k] <= s_den;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];
endmodule
`default_nettype wire

FILE: hw/rtl/two_pass_velocity_solve.sv
`default_nettype none
// Per-pixel two-pass velocity solve. Each request carries the two pass displacements, their
// errors and the 2x2 matrices A and B; each result carries vx, vy, the two inverse variances
// and a no-solution flag in tuser. One request is taken every clock while s_axis_tready is high;
// each result passes through the 32-stage coefficient divider and the 33-stage weight
// divider, both pipelined one quotient bit per stage. The output holds a register and a
// skid entry, so s_axis_tready drops only while both are full. Write det_threshold while idle.
module two_pass_velocity_solve #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tpvs_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // asc_disp, desc_disp, asc_err, desc_err, a_00, a_01, a_10, a_11, b_00, b_01, b_10, b_11
    input  wire logic [tpvs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // vel_x, vel_y, weight_x, weight_y
    output logic [tpvs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // no_solution
    output logic [tpvs_pkg::OUT_TUSER_W-1:0]       m_axis_tuser
);
    import tpvs_pkg::*;

    localparam int F    = COEF_FRAC_BITS;
    localparam int P_W  = 2 * COEF_W;
    localparam int CS_W = 50;
    localparam int PD_W = 2 * C_W;
    localparam int PN_W = C_W + COEF_W;
    localparam int DT_W = PD_W + 1;
    localparam int NM_W = PN_W + 1;
    localparam int NW   = NM_W + F + 1;
    localparam int OV_W = DIV1_DW + 31;
    localparam int VM_W = C_W + DISP_W;
    localparam int VS_W = VM_W + 1;
    localparam int EM_W = C_W + ERR_W;
    localparam int T_W  = 31;
    localparam int SQ_W = 2 * T_W;
    localparam int VR_W = SQ_W + 1;

    localparam logic signed [CS_W-1:0] CS_ONE  = CS_W'(1) << (2 * F);
    localparam logic signed [CS_W-1:0] CS_HALF = CS_W'(1) << (F - 1);
    localparam logic signed [CS_W-1:0] CS_HI   = (CS_W'(1) << 30) - CS_W'(1);
    localparam logic signed [CS_W-1:0] CS_LO   = -(CS_W'(1) << 30);
    localparam logic [31:0]            Q_POS   = (32'd1 << 30) - 32'd1;
    localparam logic [31:0]            Q_NEG   = 32'd1 << 30;
    localparam logic [EM_W:0]          EM_HALF = (EM_W + 1)'(1) << (F - 1);
    localparam logic [EM_W:0]          T_MAX   = (EM_W + 1)'(32'h7FFF_FFFF);
    localparam logic signed [VS_W-1:0] VS_HALF = VS_W'(1) << (F - 1);
    localparam logic signed [VS_W-1:0] VS_HI   = VS_W'(32'h7FFF_FFFF);
    localparam logic signed [VS_W-1:0] VS_LO   = -(VS_W'(1) << 31);
    localparam logic [DIV2_DW-1:0]     W_ONE   = DIV2_DW'(1) << 32;

    typedef struct packed {
        logic signed [DISP_W-1:0] ap;
        logic signed [DISP_W-1:0] dp;
        logic [ERR_W-1:0]         ae;
        logic [ERR_W-1:0]         de;
    } t_base;

    typedef struct packed {
        t_base            b;
        logic             nosol;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
    } t_dl1;

    typedef struct packed {
        logic             nosol;
        logic [VEL_W-1:0] vx;
        logic [VEL_W-1:0] vy;
        logic [1:0]       var0;
    } t_dl2;

    function automatic logic signed [C_W-1:0] round_c(input logic signed [CS_W-1:0] x);
        logic signed [CS_W-1:0] y;
        logic signed [CS_W-1:0] s;
        y = x + CS_HALF;
        s = y >>> F;
        if (s > CS_HI) begin
            return CS_HI[C_W-1:0];
        end else if (s < CS_LO) begin
            return CS_LO[C_W-1:0];
        end
        return s[C_W-1:0];
    endfunction

    logic                 en;
    logic [CFG_W-1:0]     r_thr;

    logic [13:1]          r_v;
    logic [DIV1_QW-1:0]   r_dl1_v;
    logic [DIV2_QW-1:0]   r_dl2_v;

    t_base                           r_s1_b, r_s2_b, r_s3_b, r_s4_b, r_s5_b, r_s6_b, r_s7_b;
    logic signed [COEF_W-1:0]        r_s1_a [LANES];
    logic signed [COEF_W-1:0]        r_s2_a [LANES];
    logic signed [COEF_W-1:0]        r_s3_a [LANES];
    logic signed [P_W-1:0]           r_s1_p [8];
    logic signed [CS_W-1:0]          r_s2_cw [LANES];
    logic signed [C_W-1:0]           r_s3_c [LANES];
    logic signed [PD_W-1:0]          r_s4_pd [2];
    logic signed [PN_W-1:0]          r_s4_pn [8];
    logic signed [DT_W-1:0]          r_s5_det;
    logic signed [NM_W-1:0]          r_s5_num [LANES];
    logic [DIV1_DW-1:0]              r_s6_d;
    logic [NM_W-1:0]                 r_s6_u [LANES];
    logic [LANES-1:0]                r_s6_neg;
    logic                            r_s6_nosol;
    logic [DIV1_DW-1:0]              r_s7_d;
    logic [DIV1_DW-1:0]              r_s7_rem [LANES];
    logic [DIV1_QW-1:0]              r_s7_low [LANES];
    logic [LANES-1:0]                r_s7_ovf;
    logic [LANES-1:0]                r_s7_neg;
    logic                            r_s7_nosol;
    t_dl1                            r_dl1 [DIV1_QW];
    logic [DIV1_QW-1:0]              w_quo1 [LANES];
    t_dl1                            w_d1;

    t_base                           r_s8_b;
    logic                            r_s8_nosol, r_s9_nosol, r_s10_nosol, r_s11_nosol;
    logic                            r_s12_nosol, r_s13_nosol;
    logic signed [C_W-1:0]           r_s8_d [LANES];
    logic [C_W-1:0]                  r_s8_mag [LANES];
    logic signed [VM_W-1:0]          r_s9_vm [LANES];
    logic [EM_W-1:0]                 r_s9_em [LANES];
    logic signed [VS_W-1:0]          r_s10_vs [2];
    logic [T_W-1:0]                  r_s10_t [LANES];
    logic [VEL_W-1:0]                r_s11_vel [2];
    logic [SQ_W-1:0]                 r_s11_sq [LANES];
    logic [VEL_W-1:0]                r_s12_vel [2];
    logic [VR_W-1:0]                 r_s12_var [2];
    logic [VEL_W-1:0]                r_s13_vel [2];
    logic [DIV2_DW-1:0]              r_s13_den [2];
    logic [DIV2_DW-1:0]              r_s13_rem [2];
    logic [DIV2_QW-1:0]              r_s13_low [2];
    logic [1:0]                      r_s13_var0;
    t_dl2                            r_dl2 [DIV2_QW];
    logic [DIV2_QW-1:0]              w_quo2 [2];
    t_dl2                            w_d2;

    logic                            r_out_v, r_skid_v;
    logic [OUT_TDATA_W-1:0]          r_out_data, r_skid_data;
    logic                            r_out_user, r_skid_user;
    logic [OUT_TDATA_W-1:0]          n_res_data;
    logic                            n_res_user;
    logic [WGT_W-1:0]                n_wgt [2];

    t_base                           n_s1_b;
    logic signed [COEF_W-1:0]        n_a [LANES];
    logic signed [COEF_W-1:0]        n_b [LANES];
    logic signed [P_W-1:0]           n_s1_p [8];
    logic signed [CS_W-1:0]          n_s2_cw [LANES];
    logic signed [PD_W-1:0]          n_s4_pd [2];
    logic signed [PN_W-1:0]          n_s4_pn [8];
    logic signed [DT_W-1:0]          n_thr;
    logic [NM_W-1:0]                 n_s6_u [LANES];
    logic [NW-1:0]                   n_s7_n [LANES];
    logic [LANES-1:0]                n_s7_ovf;
    logic [32:0]                     n_qp [LANES];
    logic [31:0]                     n_lim [LANES];
    logic [31:0]                     n_mag [LANES];
    logic [EM_W:0]                   n_e [LANES];
    logic [EM_W:0]                   n_sh [LANES];
    logic signed [VS_W-1:0]          n_vy [2];
    logic signed [VS_W-1:0]          n_vsh [2];
    logic [DIV2_DW-1:0]              n_m [2];

    assign en            = !r_skid_v;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_dl1_v <= '0;
            r_dl2_v <= '0;
        end else if (en) begin
            r_v     <= {r_v[12:8], r_dl1_v[DIV1_QW-1], r_v[6:1], s_axis_tvalid};
            r_dl1_v <= {r_dl1_v[DIV1_QW-2:0], r_v[7]};
            r_dl2_v <= {r_dl2_v[DIV2_QW-2:0], r_v[13]};
        end
    end

    always_comb begin
        n_s1_b.ap = s_axis_tdata[31:0];
        n_s1_b.dp = s_axis_tdata[63:32];
        n_s1_b.ae = s_axis_tdata[87:64];
        n_s1_b.de = s_axis_tdata[111:88];
        for (int k = 0; k < LANES; k++) begin
            n_a[k] = s_axis_tdata[112 + COEF_W*k +: COEF_W];
            n_b[k] = s_axis_tdata[208 + COEF_W*k +: COEF_W];
        end
        n_s1_p[0] = P_W'(n_a[0]) * P_W'(n_b[0]);
        n_s1_p[1] = P_W'(n_a[1]) * P_W'(n_b[2]);
        n_s1_p[2] = P_W'(n_a[0]) * P_W'(n_b[1]);
        n_s1_p[3] = P_W'(n_a[1]) * P_W'(n_b[3]);
        n_s1_p[4] = P_W'(n_a[2]) * P_W'(n_b[0]);
        n_s1_p[5] = P_W'(n_a[3]) * P_W'(n_b[2]);
        n_s1_p[6] = P_W'(n_a[2]) * P_W'(n_b[1]);
        n_s1_p[7] = P_W'(n_a[3]) * P_W'(n_b[3]);
    end

    always_comb begin
        n_s2_cw[0] = CS_ONE - (CS_W'(r_s1_p[0]) + CS_W'(r_s1_p[1]));
        n_s2_cw[1] = -(CS_W'(r_s1_p[2]) + CS_W'(r_s1_p[3]));
        n_s2_cw[2] = -(CS_W'(r_s1_p[4]) + CS_W'(r_s1_p[5]));
        n_s2_cw[3] = CS_ONE - (CS_W'(r_s1_p[6]) + CS_W'(r_s1_p[7]));
    end

    always_comb begin
        n_s4_pd[0] = PD_W'(r_s3_c[0]) * PD_W'(r_s3_c[3]);
        n_s4_pd[1] = PD_W'(r_s3_c[1]) * PD_W'(r_s3_c[2]);
        n_s4_pn[0] = PN_W'(r_s3_c[3]) * PN_W'(r_s3_a[0]);
        n_s4_pn[1] = PN_W'(r_s3_c[1]) * PN_W'(r_s3_a[2]);
        n_s4_pn[2] = PN_W'(r_s3_c[3]) * PN_W'(r_s3_a[1]);
        n_s4_pn[3] = PN_W'(r_s3_c[1]) * PN_W'(r_s3_a[3]);
        n_s4_pn[4] = PN_W'(r_s3_c[0]) * PN_W'(r_s3_a[2]);
        n_s4_pn[5] = PN_W'(r_s3_c[2]) * PN_W'(r_s3_a[0]);
        n_s4_pn[6] = PN_W'(r_s3_c[0]) * PN_W'(r_s3_a[3]);
        n_s4_pn[7] = PN_W'(r_s3_c[2]) * PN_W'(r_s3_a[1]);
    end

    always_comb begin
        n_thr = $signed({{(DT_W - CFG_W - F){1'b0}}, r_thr, {F{1'b0}}});
        for (int k = 0; k < LANES; k++) begin
            n_s6_u[k] = r_s5_num[k][NM_W-1] ? NM_W'(-r_s5_num[k]) : NM_W'(r_s5_num[k]);
            n_s7_n[k] = {r_s6_u[k], {(F + 1){1'b0}}};
            n_s7_ovf[k] = {{(OV_W - NM_W){1'b0}}, r_s6_u[k]}
                          >= ({{(OV_W - DIV1_DW){1'b0}}, r_s6_d} << (31 - F));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_b <= n_s1_b;
            r_s2_b <= r_s1_b;
            r_s3_b <= r_s2_b;
            r_s4_b <= r_s3_b;
            r_s5_b <= r_s4_b;
            r_s6_b <= r_s5_b;
            r_s7_b <= r_s6_b;
            r_s1_p <= n_s1_p;
            r_s1_a <= n_a;
            r_s2_a <= r_s1_a;
            r_s3_a <= r_s2_a;
            r_s2_cw <= n_s2_cw;
            for (int k = 0; k < LANES; k++) begin
                r_s3_c[k] <= round_c(r_s2_cw[k]);
            end
            r_s4_pd <= n_s4_pd;
            r_s4_pn <= n_s4_pn;
            r_s5_det <= DT_W'(r_s4_pd[0]) - DT_W'(r_s4_pd[1]);
            for (int k = 0; k < LANES; k++) begin
                r_s5_num[k] <= NM_W'(r_s4_pn[2*k]) - NM_W'(r_s4_pn[2*k+1]);
                r_s6_neg[k] <= r_s5_num[k][NM_W-1];
                r_s7_rem[k] <= DIV1_DW'(n_s7_n[k][NW-1:32]);
                r_s7_low[k] <= n_s7_n[k][31:0];
            end
            r_s6_u     <= n_s6_u;
            r_s6_d     <= r_s5_det[DIV1_DW-1:0];
            r_s6_nosol <= (r_s5_det < n_thr) || (r_s5_det == '0);
            r_s7_d     <= r_s6_d;
            r_s7_ovf   <= n_s7_ovf;
            r_s7_neg   <= r_s6_neg;
            r_s7_nosol <= r_s6_nosol;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_div1
        tpvs_div #(.DW(DIV1_DW), .QW(DIV1_QW)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (r_s7_rem[g]),
            .i_low (r_s7_low[g]),
            .i_den (r_s7_d),
            .o_quo (w_quo1[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl1[0] <= '{b: r_s7_b, nosol: r_s7_nosol, neg: r_s7_neg, ovf: r_s7_ovf};
            for (int k = 1; k < DIV1_QW; k++) begin
                r_dl1[k] <= r_dl1[k-1];
            end
        end
    end

    assign w_d1 = r_dl1[DIV1_QW-1];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_qp[k]  = {1'b0, w_quo1[k]} + 33'd1;
            n_lim[k] = w_d1.neg[k] ? Q_NEG : Q_POS;
            n_mag[k] = (w_d1.ovf[k] || (n_qp[k][32:1] > n_lim[k])) ? n_lim[k] : n_qp[k][32:1];
            n_e[k]   = {1'b0, r_s9_em[k]} + EM_HALF;
            n_sh[k]  = n_e[k] >> F;
        end
        for (int j = 0; j < 2; j++) begin
            n_vy[j]  = r_s10_vs[j] + VS_HALF;
            n_vsh[j] = n_vy[j] >>> F;
            n_m[j]   = W_ONE + DIV2_DW'(r_s12_var[j] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8_b      <= w_d1.b;
            r_s8_nosol  <= w_d1.nosol;
            r_s9_nosol  <= r_s8_nosol;
            r_s10_nosol <= r_s9_nosol;
            r_s11_nosol <= r_s10_nosol;
            r_s12_nosol <= r_s11_nosol;
            r_s13_nosol <= r_s12_nosol;
            for (int k = 0; k < LANES; k++) begin
                r_s8_mag[k] <= n_mag[k][C_W-1:0];
                r_s8_d[k]   <= w_d1.neg[k] ? -$signed(n_mag[k][C_W-1:0])
                                           : $signed(n_mag[k][C_W-1:0]);
                r_s9_vm[k]  <= VM_W'(r_s8_d[k])
                               * VM_W'((k % 2 == 0) ? r_s8_b.ap : r_s8_b.dp);
                r_s9_em[k]  <= EM_W'(r_s8_mag[k])
                               * EM_W'((k % 2 == 0) ? r_s8_b.ae : r_s8_b.de);
                r_s10_t[k]  <= (n_sh[k] > T_MAX) ? T_MAX[T_W-1:0] : n_sh[k][T_W-1:0];
                r_s11_sq[k] <= SQ_W'(r_s10_t[k]) * SQ_W'(r_s10_t[k]);
            end
            for (int j = 0; j < 2; j++) begin
                r_s10_vs[j]  <= VS_W'(r_s9_vm[2*j]) + VS_W'(r_s9_vm[2*j+1]);
                r_s11_vel[j] <= (n_vsh[j] > VS_HI) ? VS_HI[VEL_W-1:0]
                              : (n_vsh[j] < VS_LO) ? VS_LO[VEL_W-1:0]
                              : n_vsh[j][VEL_W-1:0];
                r_s12_vel[j] <= r_s11_vel[j];
                r_s12_var[j] <= VR_W'(r_s11_sq[2*j]) + VR_W'(r_s11_sq[2*j+1]);
                r_s13_vel[j] <= r_s12_vel[j];
                r_s13_den[j] <= r_s12_var[j];
                r_s13_rem[j] <= DIV2_DW'(n_m[j][DIV2_DW-1:DIV2_QW]);
                r_s13_low[j] <= n_m[j][DIV2_QW-1:0];
                r_s13_var0[j] <= (r_s12_var[j] == '0);
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_div2
        tpvs_div #(.DW(DIV2_DW), .QW(DIV2_QW)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (r_s13_rem[g]),
            .i_low (r_s13_low[g]),
            .i_den (r_s13_den[g]),
            .o_quo (w_quo2[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl2[0] <= '{nosol: r_s13_nosol, vx: r_s13_vel[0], vy: r_s13_vel[1],
                          var0: r_s13_var0};
            for (int k = 1; k < DIV2_QW; k++) begin
                r_dl2[k] <= r_dl2[k-1];
            end
        end
    end

    assign w_d2 = r_dl2[DIV2_QW-1];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n_wgt[j] = (w_d2.var0[j] || w_quo2[j][DIV2_QW-1]) ? WGT_MAX
                                                              : w_quo2[j][WGT_W-1:0];
        end
        if (w_d2.nosol) begin
            n_res_data = {{(2*WGT_W){1'b0}}, VEL_NONE, VEL_NONE};
        end else begin
            n_res_data = {n_wgt[1], n_wgt[0], w_d2.vy, w_d2.vx};
        end
        n_res_user = w_d2.nosol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r_dl2_v[DIV2_QW-1];
            end
        end else if (en && r_dl2_v[DIV2_QW-1]) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else begin
                r_out_data <= n_res_data;
                r_out_user <= n_res_user;
            end
        end else if (en) begin
            r_skid_data <= n_res_data;
            r_skid_user <= n_res_user;
        end
    end

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output entry");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !m_axis_tready))
        else $error("skid entry filled while output was free");

    a_nosol_forced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata == {{(2*WGT_W){1'b0}}, VEL_NONE, VEL_NONE}))
        else $error("no-solution result carries data");
`endif
endmodule
`default_nettype wire

FILE: verif/two_pass_velocity_solve_tb.sv
`timescale 1ns / 1ps

module two_pass_velocity_solve_tb;
    import tpvs_pkg::*;

    localparam int FRAC = 16;
    localparam int RANDOM_ITEMS = 900;

    typedef struct {
        logic signed [DISP_W-1:0] asc_disp;
        logic signed [DISP_W-1:0] desc_disp;
        logic [ERR_W-1:0]         asc_err;
        logic [ERR_W-1:0]         desc_err;
        logic signed [COEF_W-1:0] a [4];
        logic signed [COEF_W-1:0] b [4];
    } t_pixel;

    typedef struct packed {
        logic [VEL_W-1:0] vel_x;
        logic [VEL_W-1:0] vel_y;
        logic [WGT_W-1:0] weight_x;
        logic [WGT_W-1:0] weight_y;
        logic             no_solution;
    } t_velocity;

    typedef struct {
        t_pixel    pix;
        bit        typed;
        t_velocity want;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_W-1:0]       i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    logic [CFG_W-1:0] det_thr;
    t_velocity        pending_q [$];
    t_stim_row        stim_table [$];
    int               mismatches;
    int               orphans;
    bit               gaps_on;
    bit               stalls_on;
    int               hold_left;

    two_pass_velocity_solve u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // asc_disp, desc_disp, asc_err, desc_err, a_00, a_01, a_10, a_11, b_00..b_11
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // vel_x, vel_y, weight_x, weight_y
        .m_axis_tdata  (m_axis_tdata),
        // no_solution
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic longint round_half_up(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp64(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint round_coef(longint x);
        return clamp64(round_half_up(x, FRAC), -(longint'(1) <<< 30),
                       (longint'(1) <<< 30) - 1);
    endfunction

    function automatic longint coef_quotient(longint num, longint den);
        longint unsigned u;
        longint unsigned d;
        longint unsigned q;
        longint unsigned r;
        bit neg;
        neg = num < 0;
        u = neg ? longint'(-num) : longint'(num);
        d = den;
        q = u / d;
        r = u % d;
        if (q >= (64'd1 << 30))
            return neg ? -(longint'(1) <<< 30) : (longint'(1) <<< 30) - 1;
        for (int i = 0; i <= FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        q = (q + 1) >> 1;
        if (neg) begin
            if (q > (64'd1 << 30))
                q = 64'd1 << 30;
            return -longint'(q);
        end
        if (q > (64'd1 << 30) - 1)
            q = (64'd1 << 30) - 1;
        return longint'(q);
    endfunction

    function automatic longint unsigned err_square(longint d, logic [ERR_W-1:0] err);
        longint mag;
        longint t;
        mag = d < 0 ? -d : d;
        t = round_half_up(mag * longint'({40'd0, err}), FRAC);
        if (t > 64'h7FFF_FFFF)
            t = 64'h7FFF_FFFF;
        return longint'(t) * longint'(t);
    endfunction

    function automatic logic [WGT_W-1:0] inverse_variance(longint unsigned v);
        longint unsigned q;
        if (v == 0)
            return WGT_MAX;
        q = ((64'd1 << 32) + v / 2) / v;
        return q > 64'hFFFF_FFFF ? WGT_MAX : q[WGT_W-1:0];
    endfunction

    function automatic t_velocity solve_velocity(t_pixel p);
        longint one;
        longint a [4];
        longint b [4];
        longint c00, c01, c10, c11, det;
        longint d00, d01, d10, d11, vx, vy, ap, dp;
        t_velocity r;
        one = longint'(1) <<< (2 * FRAC);
        for (int i = 0; i < 4; i++) begin
            a[i] = p.a[i];
            b[i] = p.b[i];
        end
        ap = p.asc_disp;
        dp = p.desc_disp;
        c00 = round_coef(one - (a[0] * b[0] + a[1] * b[2]));
        c01 = round_coef(-(a[0] * b[1] + a[1] * b[3]));
        c10 = round_coef(-(a[2] * b[0] + a[3] * b[2]));
        c11 = round_coef(one - (a[2] * b[1] + a[3] * b[3]));
        det = c00 * c11 - c01 * c10;
        if (det < (longint'({41'd0, det_thr}) <<< FRAC) || det == 0) begin
            r.vel_x = VEL_NONE;
            r.vel_y = VEL_NONE;
            r.weight_x = '0;
            r.weight_y = '0;
            r.no_solution = 1'b1;
            return r;
        end
        d00 = coef_quotient(c11 * a[0] - c01 * a[2], det);
        d01 = coef_quotient(c11 * a[1] - c01 * a[3], det);
        d10 = coef_quotient(c00 * a[2] - c10 * a[0], det);
        d11 = coef_quotient(c00 * a[3] - c10 * a[1], det);
        vx = clamp64(round_half_up(d00 * ap + d01 * dp, FRAC), -(longint'(1) <<< 31),
                     (longint'(1) <<< 31) - 1);
        vy = clamp64(round_half_up(d10 * ap + d11 * dp, FRAC), -(longint'(1) <<< 31),
                     (longint'(1) <<< 31) - 1);
        r.vel_x = vx[31:0];
        r.vel_y = vy[31:0];
        r.weight_x = inverse_variance(err_square(d00, p.asc_err) + err_square(d01, p.desc_err));
        r.weight_y = inverse_variance(err_square(d10, p.asc_err) + err_square(d11, p.desc_err));
        r.no_solution = 1'b0;
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_pixel(t_pixel p);
        return {p.b[3], p.b[2], p.b[1], p.b[0], p.a[3], p.a[2], p.a[1], p.a[0],
                p.desc_err, p.asc_err, p.desc_disp, p.asc_disp};
    endfunction

    task automatic send_pixel(t_pixel p, bit typed, t_velocity want);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_pixel(p);
        do @(posedge i_clk); while (!s_axis_tready);
        pending_q.push_back(typed ? want : solve_velocity(p));
    endtask

    task automatic write_threshold(logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        det_thr = v;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic signed [COEF_W-1:0] rand_coef(bit wide);
        int span;
        if (wide)
            return COEF_W'($urandom);
        span = ($urandom_range(0, 3) == 0) ? 131072 : 32768;
        return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel p;
        bit wide;
        wide = $urandom_range(0, 4) == 0;
        p.asc_disp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65535) - 32768;
        p.desc_disp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65535) - 32768;
        p.asc_err = ERR_W'($urandom >> $urandom_range(8, 31));
        p.desc_err = ERR_W'($urandom >> $urandom_range(8, 31));
        for (int i = 0; i < 4; i++) begin
            p.a[i] = rand_coef(wide);
            p.b[i] = rand_coef(wide);
        end
        if ($urandom_range(0, 9) == 0) begin
            p.asc_err = ERR_W'($urandom);
            p.desc_err = ERR_W'($urandom);
        end
        return p;
    endfunction

    function automatic t_pixel blank_pixel();
        t_pixel p;
        p.asc_disp = '0;
        p.desc_disp = '0;
        p.asc_err = '0;
        p.desc_err = '0;
        for (int i = 0; i < 4; i++) begin
            p.a[i] = '0;
            p.b[i] = '0;
        end
        return p;
    endfunction

    task automatic add_row(t_pixel p, bit typed, t_velocity want);
        t_stim_row row;
        row.pix = p;
        row.typed = typed;
        row.want = want;
        stim_table.push_back(row);
    endtask

    task automatic build_table();
        t_pixel p;
        t_velocity w;
        t_velocity none_w;
        none_w = '{VEL_NONE, VEL_NONE, '0, '0, 1'b1};
        // zero A: velocity zero, variance zero
        p = blank_pixel();
        p.asc_disp = 32'h7FFF_FFFF;
        p.desc_disp = 32'h8000_0000;
        p.asc_err = 24'hFF_FFFF;
        p.desc_err = 24'hFF_FFFF;
        w = '{'0, '0, WGT_MAX, WGT_MAX, 1'b0};
        add_row(p, 1, w);
        // identity A, zero B: velocity equals displacement, first with zero errors
        p = blank_pixel();
        p.a[0] = 24'sd65536;
        p.a[3] = 24'sd65536;
        p.asc_disp = 32'h7FFF_FFFF;
        p.desc_disp = 32'h8000_0000;
        w = '{32'h7FFF_FFFF, 32'h8000_0000, WGT_MAX, WGT_MAX, 1'b0};
        add_row(p, 1, w);
        p.asc_disp = 32'h8000_0000;
        p.desc_disp = 32'h7FFF_FFFF;
        w = '{32'h8000_0000, 32'h7FFF_FFFF, WGT_MAX, WGT_MAX, 1'b0};
        add_row(p, 1, w);
        p.asc_err = 24'hFF_FFFF;
        p.desc_err = 24'h00_0001;
        add_row(p, 0, w);
        // extreme A and B: first determinant zero, second large and positive
        p = blank_pixel();
        for (int i = 0; i < 4; i++) begin
            p.a[i] = 24'sh7F_FFFF;
            p.b[i] = 24'sh7F_FFFF;
        end
        add_row(p, 1, none_w);
        for (int i = 0; i < 4; i++) begin
            p.a[i] = 24'sh80_0000;
            p.b[i] = (i == 1 || i == 2) ? 24'sh7F_FFFF : 24'sh80_0000;
        end
        add_row(p, 0, none_w);
        // A = B = I: C is zero, determinant zero
        p = blank_pixel();
        p.a[0] = 24'sd65536;
        p.a[3] = 24'sd65536;
        p.b[0] = 24'sd65536;
        p.b[3] = 24'sd65536;
        add_row(p, 1, none_w);
        // large D, small determinant: below the reset threshold, so no solution
        p = blank_pixel();
        p.a[0] = 24'sh7F_FFFF;
        p.a[3] = 24'sh80_0000;
        p.b[0] = 24'sd511;
        p.b[3] = -24'sd511;
        p.asc_disp = 32'h7FFF_FFFF;
        p.desc_disp = 32'h7FFF_FFFF;
        p.asc_err = 24'hFF_FFFF;
        p.desc_err = 24'hFF_FFFF;
        add_row(p, 0, w);
        for (int k = 0; k < 12; k++)
            add_row(rand_pixel(), 0, w);
    endtask

    // compare every result and drive m_axis_tready with random stalls
    initial begin
        t_velocity got;
        t_velocity want;
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.vel_x = m_axis_tdata[31:0];
                got.vel_y = m_axis_tdata[63:32];
                got.weight_x = m_axis_tdata[95:64];
                got.weight_y = m_axis_tdata[127:96];
                got.no_solution = m_axis_tuser[0];
                if (pending_q.size() == 0) begin
                    orphans++;
                    if (mismatches + orphans <= 10)
                        $display("unexpected result %h/%b", m_axis_tdata, m_axis_tuser);
                end else begin
                    want = pending_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches + orphans <= 10)
                            $display("mismatch exp %h %h %h %h %b act %h %h %h %h %b",
                                     want.vel_x, want.vel_y, want.weight_x, want.weight_y,
                                     want.no_solution, got.vel_x, got.vel_y, got.weight_x,
                                     got.weight_y, got.no_solution);
                    end
                end
                stall = stalls_on ? $urandom_range(0, 19) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] thr_list [6];
        int per_phase;
        t_velocity dummy;
        dummy = '{'0, '0, '0, '0, 1'b0};
        mismatches = 0;
        orphans = 0;
        hold_left = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        det_thr = THR_RESET;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        build_table();
        foreach (stim_table[i])
            send_pixel(stim_table[i].pix, stim_table[i].typed, stim_table[i].want);
        drain_results();

        thr_list = '{23'd0, 23'h7F_FFFF, 23'd1, 23'd0, THR_RESET, 23'd0};
        thr_list[3] = CFG_W'($urandom_range(0, 23'h7F_FFFF));
        per_phase = RANDOM_ITEMS / 6;
        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(thr_list[ph]);
            gaps_on = ph != 2;
            stalls_on = ph != 4;
            if (ph == 1)
                hold_left = 600;
            if (ph == 0)
                send_pixel(stim_table[6].pix, 0, dummy);
            for (int k = 0; k < per_phase; k++)
                send_pixel(rand_pixel(), 0, dummy);
            drain_results();
        end

        if (mismatches == 0 && orphans == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
